// File: design/mfht_pkg.sv
// Shared types and constants for the muon first hit time pipeline.
// No dependencies; used by the top level and its arithmetic units.
package mfht_pkg;

  typedef enum logic [1:0] {
    REG_SCINT_INDEX = 2'd0,
    REG_WATER_INDEX = 2'd1,
    REG_LIGHT_SPEED = 2'd2,
    REG_MUON_SPEED  = 2'd3
  } cfg_reg_t;

  localparam logic [1:0] MED_SCINT = 2'd1;
  localparam logic [1:0] MED_WATER = 2'd2;

  localparam logic [15:0] SCINT_INDEX_RST = 16'd24330;
  localparam logic [15:0] WATER_INDEX_RST = 16'd21955;
  localparam logic [16:0] LIGHT_SPEED_RST = 17'd76747;
  localparam logic [16:0] MUON_SPEED_RST  = 17'd76747;

  localparam int SQ_W    = 48;
  localparam int DIV1_NW = 53;
  localparam int DIV1_DW = 16;
  localparam int DIV2_NW = 58;
  localparam int DIV2_DW = 23;
  localparam int HIT_W   = 28;

  typedef struct packed {
    logic [1:0]         med;
    logic signed [23:0] t0;
    logic [19:0]        len;
    logic [15:0]        n;
    logic signed [38:0] s;
    logic [23:0]        dstart;
    logic [23:0]        dend;
  } sb_t;

endpackage

// File: design/mfht_isqrt.sv
// Pipelined floor square root, one result bit per register stage.
// Uses mfht_pkg for its default width; advances only while adv is high.
module mfht_isqrt #(
  parameter int W = mfht_pkg::SQ_W
) (
  input  logic           clk,
  input  logic           adv,
  input  logic [W-1:0]   rad,
  output logic [W/2-1:0] root
);

  localparam int R = W / 2;

  logic [W-1:0] rad_q  [R];
  logic [R+1:0] rem_q  [R];
  logic [R-1:0] root_q [R];

  for (genvar k = 0; k < R; k++) begin : g_step
    logic [W-1:0] rad_c;
    logic [R+1:0] rem_c;
    logic [R-1:0] root_c;
    logic [R+3:0] remx;
    logic [R+3:0] trial;
    logic [R+3:0] diff;
    logic         ge;

    if (k == 0) begin : g_first
      assign rad_c  = rad;
      assign rem_c  = '0;
      assign root_c = '0;
    end else begin : g_next
      assign rad_c  = rad_q[k-1];
      assign rem_c  = rem_q[k-1];
      assign root_c = root_q[k-1];
    end

    assign remx  = {rem_c, rad_c[W-1-2*k -: 2]};
    assign trial = {2'b00, root_c, 2'b01};
    assign ge    = remx >= trial;
    assign diff  = remx - trial;

    always_ff @(posedge clk) begin
      if (adv) begin
        rad_q[k]  <= rad_c;
        rem_q[k]  <= ge ? diff[R+1:0] : remx[R+1:0];
        root_q[k] <= {root_c[R-2:0], ge};
      end
    end
  end

  assign root = root_q[R-1];

endmodule

// File: design/mfht_div.sv
// Pipelined unsigned restoring divider, one quotient bit per register stage.
// Uses mfht_pkg for its default widths; advances only while adv is high. Divisor must be nonzero.
module mfht_div #(
  parameter int NW = mfht_pkg::DIV1_NW,
  parameter int DW = mfht_pkg::DIV1_DW
) (
  input  logic          clk,
  input  logic          adv,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic [NW-1:0] quo
);

  logic [NW-1:0] num_q [NW];
  logic [DW-1:0] den_q [NW];
  logic [DW-1:0] rem_q [NW];
  logic [NW-1:0] quo_q [NW];

  for (genvar k = 0; k < NW; k++) begin : g_step
    logic [NW-1:0] num_c;
    logic [DW-1:0] den_c;
    logic [DW-1:0] rem_c;
    logic [NW-1:0] quo_c;
    logic [DW:0]   trial;
    logic [DW:0]   diff;
    logic          ge;

    if (k == 0) begin : g_first
      assign num_c = num;
      assign den_c = den;
      assign rem_c = '0;
      assign quo_c = '0;
    end else begin : g_next
      assign num_c = num_q[k-1];
      assign den_c = den_q[k-1];
      assign rem_c = rem_q[k-1];
      assign quo_c = quo_q[k-1];
    end

    assign trial = {rem_c, num_c[NW-1-k]};
    assign ge    = trial >= {1'b0, den_c};
    assign diff  = trial - {1'b0, den_c};

    always_ff @(posedge clk) begin
      if (adv) begin
        num_q[k] <= num_c;
        den_q[k] <= den_c;
        rem_q[k] <= ge ? diff[DW-1:0] : trial[DW-1:0];
        quo_q[k] <= {quo_c[NW-2:0], ge};
      end
    end
  end

  assign quo = quo_q[NW-1];

endmodule

// File: design/muon_first_hit_time.sv
// Muon first Cherenkov hit time: top level, config registers and pipeline.
// Depends on mfht_pkg, mfht_isqrt and mfht_div.
//
// One item enters per cycle while the output is not stalled, and passes through
// the projection arithmetic stages, a 24 stage square root, one stage to form
// the divider operands, a 53 stage divider for the back-off and photon path, three
// stages of clamping and scaling, a 58 stage divider for the two time terms
// and the output register. The whole pipeline holds while a result waits at
// the output, so in_ready follows out_ready whenever out_valid is high.
// Configuration writes are taken at once (cfg_ready is high outside reset).
module muon_first_hit_time (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [16:0]         cfg_data,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic signed [20:0]  start_x,
  input  logic signed [20:0]  start_y,
  input  logic signed [20:0]  start_z,
  input  logic signed [23:0]  start_time,
  input  logic signed [15:0]  dir_x,
  input  logic signed [15:0]  dir_y,
  input  logic signed [15:0]  dir_z,
  input  logic [19:0]         track_length,
  input  logic signed [20:0]  sensor_x,
  input  logic signed [20:0]  sensor_y,
  input  logic signed [20:0]  sensor_z,
  input  logic [1:0]          sensor_medium,
  output logic                out_valid,
  input  logic                out_ready,
  output logic signed [27:0]  hit_time
);

  localparam int SQ_LAT = mfht_pkg::SQ_W / 2;
  localparam int SUM_W  = mfht_pkg::DIV2_NW + 3;
  localparam logic signed [SUM_W-1:0] SUM_MAX = SUM_W'(2**(mfht_pkg::HIT_W-1) - 1);
  localparam logic signed [SUM_W-1:0] SUM_MIN = -SUM_W'(2**(mfht_pkg::HIT_W-1));

  function automatic logic signed [63:0] rnd_pow2(input logic signed [63:0] v,
                                                  input int unsigned sh);
    logic signed [63:0] mag;
    logic signed [63:0] r;
    mag = v[63] ? -v : v;
    r = (mag + (64'sd1 <<< (sh - 1))) >>> sh;
    return v[63] ? -r : r;
  endfunction

  logic [15:0] scint_index;
  logic [15:0] water_index;
  logic [16:0] light_speed;
  logic [16:0] muon_speed;
  logic        adv;

  assign cfg_ready = !rst;
  assign adv       = !out_valid || out_ready;
  assign in_ready  = adv && !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      scint_index <= mfht_pkg::SCINT_INDEX_RST;
      water_index <= mfht_pkg::WATER_INDEX_RST;
      light_speed <= mfht_pkg::LIGHT_SPEED_RST;
      muon_speed  <= mfht_pkg::MUON_SPEED_RST;
    end else if (cfg_valid) begin
      unique case (mfht_pkg::cfg_reg_t'(cfg_index))
        mfht_pkg::REG_SCINT_INDEX: scint_index <= cfg_data[15:0];
        mfht_pkg::REG_WATER_INDEX: water_index <= cfg_data[15:0];
        mfht_pkg::REG_LIGHT_SPEED: light_speed <= cfg_data;
        mfht_pkg::REG_MUON_SPEED:  muon_speed  <= cfg_data;
      endcase
    end
  end

  // valid bits
  logic v1, v2, v3, v4, v5, v6, v7, v8, v9, v10, v11;
  logic vs  [SQ_LAT];
  logic vd1 [mfht_pkg::DIV1_NW];
  logic vd2 [mfht_pkg::DIV2_NW];

  always_ff @(posedge clk) begin
    if (rst) begin
      {v1, v2, v3, v4, v5, v6, v7, v8, v9, v10, v11} <= '0;
      for (int k = 0; k < SQ_LAT; k++) vs[k] <= 1'b0;
      for (int k = 0; k < mfht_pkg::DIV1_NW; k++) vd1[k] <= 1'b0;
      for (int k = 0; k < mfht_pkg::DIV2_NW; k++) vd2[k] <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
      v6 <= v5;
      v7 <= v6;
      vs[0] <= v7;
      for (int k = 1; k < SQ_LAT; k++) vs[k] <= vs[k-1];
      v8 <= vs[SQ_LAT-1];
      vd1[0] <= v8;
      for (int k = 1; k < mfht_pkg::DIV1_NW; k++) vd1[k] <= vd1[k-1];
      v9  <= vd1[mfht_pkg::DIV1_NW-1];
      v10 <= v9;
      v11 <= v10;
      vd2[0] <= v11;
      for (int k = 1; k < mfht_pkg::DIV2_NW; k++) vd2[k] <= vd2[k-1];
      out_valid <= vd2[mfht_pkg::DIV2_NW-1];
    end
  end

  // stage 1: difference vector
  logic signed [20:0] in_start  [3];
  logic signed [20:0] in_sensor [3];
  logic signed [15:0] in_dir    [3];
  logic signed [21:0] d1 [3];
  logic signed [15:0] dir1 [3];
  mfht_pkg::sb_t      sb1, sb1_next;

  always_comb begin
    in_start  = '{start_x, start_y, start_z};
    in_sensor = '{sensor_x, sensor_y, sensor_z};
    in_dir    = '{dir_x, dir_y, dir_z};
    sb1_next        = '0;
    sb1_next.med    = sensor_medium;
    sb1_next.t0     = start_time;
    sb1_next.len    = track_length;
    sb1_next.n      = (sensor_medium == mfht_pkg::MED_SCINT) ? scint_index : water_index;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        d1[i]   <= 22'(in_sensor[i]) - 22'(in_start[i]);
        dir1[i] <= in_dir[i];
      end
      sb1 <= sb1_next;
    end
  end

  // stage 2: products with the direction
  logic signed [37:0] prod2 [3];
  logic signed [36:0] dl2 [3];
  logic signed [21:0] d2 [3];
  logic signed [15:0] dir2 [3];
  mfht_pkg::sb_t      sb2;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        prod2[i] <= d1[i] * dir1[i];
        dl2[i]   <= dir1[i] * $signed({1'b0, sb1.len});
        d2[i]    <= d1[i];
        dir2[i]  <= dir1[i];
      end
      sb2 <= sb1;
    end
  end

  // stage 3: projection, index square, end point offsets, start distance terms
  logic signed [38:0] s3_next;
  logic signed [22:0] e3_next [3];
  logic [42:0]        dd3_next [3];
  logic signed [63:0] et;
  logic signed [44:0] dsq;
  logic signed [22:0] e3 [3];
  logic [42:0]        dd3 [3];
  logic [31:0]        nn3;
  logic signed [21:0] d3 [3];
  logic signed [15:0] dir3 [3];
  mfht_pkg::sb_t      sb3, sb3_next;

  always_comb begin
    s3_next = prod2[0] + prod2[1] + prod2[2];
    et  = '0;
    dsq = '0;
    for (int i = 0; i < 3; i++) begin
      et  = 64'(d2[i]) - rnd_pow2(64'(dl2[i]), 14);
      e3_next[i] = et[22:0];
      dsq = d2[i] * d2[i];
      dd3_next[i] = dsq[42:0];
    end
    sb3_next   = sb2;
    sb3_next.s = s3_next;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        e3[i]   <= e3_next[i];
        dd3[i]  <= dd3_next[i];
        d3[i]   <= d2[i];
        dir3[i] <= dir2[i];
      end
      nn3     <= sb2.n * sb2.n;
      sb3     <= sb3_next;
    end
  end

  // stage 4
  logic signed [54:0] ps4 [3];
  logic [43:0]        ee4_next [3];
  logic signed [45:0] esq;
  logic [43:0]        ee4 [3];
  logic [44:0]        dsum4;
  logic [31:0]        tsq4;
  logic signed [21:0] d4 [3];
  mfht_pkg::sb_t      sb4;

  always_comb begin
    esq = '0;
    for (int i = 0; i < 3; i++) begin
      esq = e3[i] * e3[i];
      ee4_next[i] = esq[43:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        ps4[i] <= dir3[i] * sb3.s;
        ee4[i] <= ee4_next[i];
        d4[i]  <= d3[i];
      end
      dsum4 <= 45'(dd3[0]) + 45'(dd3[1]) + 45'(dd3[2]);
      tsq4  <= (nn3 > 32'h1000_0000) ? nn3 - 32'h1000_0000 : '0;
      sb4   <= sb3;
    end
  end

  // stage 5: perpendicular components
  logic signed [24:0] p5_next [3];
  logic signed [63:0] pt;
  logic signed [24:0] p5 [3];
  logic [45:0]        esum5;
  logic [44:0]        dsum5;
  logic [31:0]        tsq5;
  mfht_pkg::sb_t      sb5;

  always_comb begin
    pt = '0;
    for (int i = 0; i < 3; i++) begin
      pt = 64'(d4[i]) - rnd_pow2(64'(ps4[i]), 28);
      p5_next[i] = pt[24:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p5    <= p5_next;
      esum5 <= 46'(ee4[0]) + 46'(ee4[1]) + 46'(ee4[2]);
      dsum5 <= dsum4;
      tsq5  <= tsq4;
      sb5   <= sb4;
    end
  end

  // stage 6
  logic [46:0]        pp6_next [3];
  logic signed [49:0] psq;
  logic [46:0]        pp6 [3];
  logic [45:0]        esum6;
  logic [44:0]        dsum6;
  logic [31:0]        tsq6;
  mfht_pkg::sb_t      sb6;

  always_comb begin
    psq = '0;
    for (int i = 0; i < 3; i++) begin
      psq = p5[i] * p5[i];
      pp6_next[i] = psq[46:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pp6   <= pp6_next;
      esum6 <= esum5;
      dsum6 <= dsum5;
      tsq6  <= tsq5;
      sb6   <= sb5;
    end
  end

  // stage 7
  logic [47:0]   sq7;
  logic [45:0]   esum7;
  logic [44:0]   dsum7;
  logic [31:0]   tsq7;
  mfht_pkg::sb_t sb7;

  always_ff @(posedge clk) begin
    if (adv) begin
      sq7   <= 48'(pp6[0]) + 48'(pp6[1]) + 48'(pp6[2]);
      esum7 <= esum6;
      dsum7 <= dsum6;
      tsq7  <= tsq6;
      sb7   <= sb6;
    end
  end

  // square roots
  logic [SQ_LAT-1:0] root_p, root_t, root_d, root_e;
  mfht_pkg::sb_t     sbs [SQ_LAT];

  mfht_isqrt #(.W(mfht_pkg::SQ_W)) u_sqrt_perp (
    .clk(clk), .adv(adv), .rad(sq7), .root(root_p));
  mfht_isqrt #(.W(mfht_pkg::SQ_W)) u_sqrt_tan (
    .clk(clk), .adv(adv), .rad(mfht_pkg::SQ_W'(tsq7)), .root(root_t));
  mfht_isqrt #(.W(mfht_pkg::SQ_W)) u_sqrt_start (
    .clk(clk), .adv(adv), .rad(mfht_pkg::SQ_W'(dsum7)), .root(root_d));
  mfht_isqrt #(.W(mfht_pkg::SQ_W)) u_sqrt_end (
    .clk(clk), .adv(adv), .rad(mfht_pkg::SQ_W'(esum7)), .root(root_e));

  always_ff @(posedge clk) begin
    if (adv) begin
      sbs[0] <= sb7;
      for (int k = 1; k < SQ_LAT; k++) sbs[k] <= sbs[k-1];
    end
  end

  // stage 8: back-off and photon path numerators
  logic [15:0]                 tan8_next;
  logic [40:0]                 pn8;
  logic [mfht_pkg::DIV1_NW-1:0] num_b8, num_d8;
  logic [mfht_pkg::DIV1_DW-1:0] den8;
  mfht_pkg::sb_t               sb8, sb8_next;

  always_comb begin
    tan8_next = (root_t[15:0] == '0) ? 16'd1 : root_t[15:0];
    pn8       = root_p[23:0] * sbs[SQ_LAT-1].n;
    sb8_next        = sbs[SQ_LAT-1];
    sb8_next.dstart = root_d[23:0];
    sb8_next.dend   = root_e[23:0];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      num_b8     <= {1'b0, root_p[23:0], 28'b0} + mfht_pkg::DIV1_NW'(tan8_next >> 1);
      num_d8     <= mfht_pkg::DIV1_NW'(pn8) + mfht_pkg::DIV1_NW'(tan8_next >> 1);
      den8       <= tan8_next;
      sb8        <= sb8_next;
    end
  end

  logic [mfht_pkg::DIV1_NW-1:0] q_back, q_dist;
  mfht_pkg::sb_t                sbd1 [mfht_pkg::DIV1_NW];

  mfht_div #(.NW(mfht_pkg::DIV1_NW), .DW(mfht_pkg::DIV1_DW)) u_div_back (
    .clk(clk), .adv(adv), .num(num_b8), .den(den8), .quo(q_back));
  mfht_div #(.NW(mfht_pkg::DIV1_NW), .DW(mfht_pkg::DIV1_DW)) u_div_dist (
    .clk(clk), .adv(adv), .num(num_d8), .den(den8), .quo(q_dist));

  always_ff @(posedge clk) begin
    if (adv) begin
      sbd1[0] <= sb8;
      for (int k = 1; k < mfht_pkg::DIV1_NW; k++) sbd1[k] <= sbd1[k-1];
    end
  end

  // stage 9: emission point and clamp
  mfht_pkg::sb_t      sb9_c, sb9, sb10, sb11;
  logic signed [54:0] a_raw, a9_next, a9;
  logic signed [54:0] lenq;
  logic [40:0]        dist9_next, dist9;

  always_comb begin
    sb9_c      = sbd1[mfht_pkg::DIV1_NW-1];
    a_raw      = 55'(sb9_c.s) - $signed({2'b00, q_back});
    lenq       = $signed({21'b0, sb9_c.len, 14'b0});
    a9_next    = a_raw;
    dist9_next = q_dist[40:0];
    if (sb9_c.med == mfht_pkg::MED_SCINT) begin
      if (a_raw < 0) begin
        a9_next    = '0;
        dist9_next = 41'(sb9_c.dstart);
      end else if (a_raw > lenq) begin
        a9_next    = lenq;
        dist9_next = 41'(sb9_c.dend);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a9    <= a9_next;
      dist9 <= dist9_next;
      sb9   <= sb9_c;
    end
  end

  // stage 10: magnitudes and path scaling
  logic [56:0] nd10;
  logic [53:0] amag10;
  logic        neg10, neg11;

  always_ff @(posedge clk) begin
    if (adv) begin
      nd10   <= sb9.n * dist9;
      amag10 <= a9[54] ? 54'(-a9) : 54'(a9);
      neg10  <= a9[54];
      sb10   <= sb9;
    end
  end

  // stage 11: time numerators
  logic [16:0]                  vm, vc;
  logic [mfht_pkg::DIV2_NW-1:0] num_t11, num_l11;
  logic [mfht_pkg::DIV2_DW-1:0] den_t11, den_l11;

  assign vm = (muon_speed == '0) ? 17'd1 : muon_speed;
  assign vc = (light_speed == '0) ? 17'd1 : light_speed;

  always_ff @(posedge clk) begin
    if (adv) begin
      num_t11 <= mfht_pkg::DIV2_NW'(amag10) + mfht_pkg::DIV2_NW'({vm, 5'b0});
      den_t11 <= {vm, 6'b0};
      num_l11 <= mfht_pkg::DIV2_NW'(nd10) + mfht_pkg::DIV2_NW'({vc, 5'b0});
      den_l11 <= {vc, 6'b0};
      neg11   <= neg10;
      sb11    <= sb10;
    end
  end

  logic [mfht_pkg::DIV2_NW-1:0] q_flight, q_light;
  mfht_pkg::sb_t                sbd2 [mfht_pkg::DIV2_NW];
  logic                         negd2 [mfht_pkg::DIV2_NW];

  mfht_div #(.NW(mfht_pkg::DIV2_NW), .DW(mfht_pkg::DIV2_DW)) u_div_flight (
    .clk(clk), .adv(adv), .num(num_t11), .den(den_t11), .quo(q_flight));
  mfht_div #(.NW(mfht_pkg::DIV2_NW), .DW(mfht_pkg::DIV2_DW)) u_div_light (
    .clk(clk), .adv(adv), .num(num_l11), .den(den_l11), .quo(q_light));

  always_ff @(posedge clk) begin
    if (adv) begin
      sbd2[0]  <= sb11;
      negd2[0] <= neg11;
      for (int k = 1; k < mfht_pkg::DIV2_NW; k++) begin
        sbd2[k]  <= sbd2[k-1];
        negd2[k] <= negd2[k-1];
      end
    end
  end

  // output: sum and saturate, or zero for an unknown medium
  mfht_pkg::sb_t                sbo;
  logic signed [SUM_W-1:0]      flight, total;
  logic signed [27:0]           hit_next;

  always_comb begin
    sbo    = sbd2[mfht_pkg::DIV2_NW-1];
    flight = $signed({3'b000, q_flight});
    if (negd2[mfht_pkg::DIV2_NW-1]) flight = -flight;
    total  = SUM_W'(sbo.t0) + flight + $signed({3'b000, q_light});
    priority if (sbo.med != mfht_pkg::MED_SCINT && sbo.med != mfht_pkg::MED_WATER) begin
      hit_next = '0;
    end else if (total > SUM_MAX) begin
      hit_next = SUM_MAX[27:0];
    end else if (total < SUM_MIN) begin
      hit_next = SUM_MIN[27:0];
    end else begin
      hit_next = total[27:0];
    end
  end

  logic [1:0] out_med;

  always_ff @(posedge clk) begin
    if (adv) begin
      hit_time <= hit_next;
      out_med  <= sbo.med;
    end
  end

  a_other_medium_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_med != mfht_pkg::MED_SCINT && out_med != mfht_pkg::MED_WATER)
      |-> hit_time == '0)
    else $error("hit time not zero for an unknown medium");

  a_scint_clamped: assert property (@(posedge clk) disable iff (rst)
    (v9 && sb9.med == mfht_pkg::MED_SCINT)
      |-> (!a9[54] && a9 <= $signed({21'b0, sb9.len, 14'b0})))
    else $error("scintillator emission point outside the track");

  a_tan_nonzero: assert property (@(posedge clk) disable iff (rst)
    v8 |-> den8 != '0)
    else $error("zero divisor entered the back-off divider");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(hit_time)))
    else $error("output dropped while stalled");

endmodule
